// ===== rtl/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types, sizes and helpers for the sorted list insert/delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 4;
  localparam int ECNT_W   = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic              success;
    logic [POS_W-1:0]  position;
    logic [ECNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic shift_ins;
    logic shift_del;
    logic load_result;
  } sli_cmd_t;

  typedef struct packed {
    logic kind;
    logic ok;
  } sli_status_t;

  // report an index modulo the position field width
  function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] p);
    logic [IDX_W+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, p};
    return t[POS_W-1:0];
  endfunction

  // report a count modulo the count field width
  function automatic logic [ECNT_W-1:0] to_ecnt(input logic [CNT_W-1:0] c);
    logic [CNT_W+ECNT_W-1:0] t;
    t = {{ECNT_W{1'b0}}, c};
    return t[ECNT_W-1:0];
  endfunction

endpackage

// ===== rtl/sorted_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Ascending list of signed 32-bit values with insert and delete-first-match.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_data  (kind, value)
//  out     | output    | out_valid/out_stall | out_data (success, position,
//          |           |                     |           entry_count)
//
//  an item is first registered; then the parallel compare, the shift of the
//  cell row and the load of the result register happen together in execution
//  the next item is taken as soon as the previous one has executed
//  execution waits while a held result is stalled
//  reset clears the count and the controller; cell contents are not cleared
// ----------------------------------------------------------------------------
module sorted_list_insert_delete import sli_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  sli_cmd_t    cmd;
  sli_status_t status;

  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sli_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .cmd     (cmd),
    .status  (status),
    .result  (out_data)
  );

endmodule

// ===== rtl/sli_dpath.sv =====
// ----------------------------------------------------------------------------
// sli_dpath
// Row of value cells with per-cell compare, shift network, count and
// result register.
// ----------------------------------------------------------------------------
module sli_dpath import sli_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_data,
  input  sli_cmd_t    cmd,
  output sli_status_t status,
  output out_item_t   result
);

  in_item_t          item;
  logic [VAL_W-1:0]  slot [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic [CAPACITY-1:0] ge_hit;
  logic [CAPACITY-1:0] eq_hit;
  logic [IDX_W-1:0]    ins_pos;
  logic [IDX_W-1:0]    del_pos;
  logic                full;
  logic                found;
  logic                ok;
  logic [IDX_W-1:0]    pos;
  logic [CNT_W+IDX_W-1:0] count_wide;

  assign count_wide = {{IDX_W{1'b0}}, count};

  // parallel compare in every valid cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_hit[i] = (CNT_W'(i) < count) && ($signed(item.value) <= $signed(slot[i]));
      eq_hit[i] = (CNT_W'(i) < count) && (item.value == slot[i]);
    end
  end

  // first hit wins; insert falls back to the end of the list
  always_comb begin
    ins_pos = count_wide[IDX_W-1:0];
    del_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (ge_hit[i]) begin
        ins_pos = IDX_W'(i);
      end
      if (eq_hit[i]) begin
        del_pos = IDX_W'(i);
      end
    end
  end

  assign full  = (count == CNT_W'(CAPACITY));
  assign found = |eq_hit;
  assign ok    = (item.kind == KIND_DELETE) ? found : !full;
  assign pos   = (item.kind == KIND_DELETE) ? del_pos : ins_pos;

  assign status.kind = item.kind;
  assign status.ok   = ok;

  always_comb begin
    count_next = count;
    if (cmd.shift_ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.shift_del) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.shift_ins) begin
        if (IDX_W'(i) == ins_pos) begin
          slot[i] <= item.value;
        end else if (i > 0 && IDX_W'(i) > ins_pos) begin
          slot[i] <= slot[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.shift_del) begin
        if (i < CAPACITY - 1 && IDX_W'(i) >= del_pos) begin
          slot[i] <= slot[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
    if (cmd.load_result) begin
      result.success     <= ok;
      result.position    <= ok ? to_pos(pos) : '0;
      result.entry_count <= to_ecnt(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");
  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_ins |-> !full)
    else $error("insert into a full list");
  a_del_found: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_del |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not drop the count");
`endif

endmodule

// ===== rtl/sli_ctrl.sv =====
// ----------------------------------------------------------------------------
// sli_ctrl
// Handshake controller: takes one item, runs it through the datapath once
// the result register is free, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module sli_ctrl import sli_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  sli_status_t status,
  output sli_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          cmd.shift_ins   = status.ok && (status.kind == KIND_INSERT);
          cmd.shift_del   = status.ok && (status.kind == KIND_DELETE);
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift_ins && cmd.shift_del))
    else $error("insert and delete shift together");
  a_shift_with_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_ins || cmd.shift_del) |-> cmd.load_result)
    else $error("list changed without a result");
  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_EXEC) && !cmd.capture)
    else $error("item capture not followed by execution");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !(out_valid && out_stall))
    else $error("result overwritten while held");
`endif

endmodule

// ===== tb/sli_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_checker
// Watches both channels of the sorted list block and keeps its own copy of
// the ascending list. Every accepted item is turned into the result it must
// give. Every accepted result is compared field by field with the oldest of
// those, and each difference is counted.
// ----------------------------------------------------------------------------
module sorted_list_checker import sli_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);

  logic signed [VAL_W-1:0] list_values[$];
  out_item_t               pending_results[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // applies one item to the list copy and works out its result
  task automatic apply_item(input in_item_t it, output out_item_t res);
    logic signed [VAL_W-1:0] v;
    int                      n;
    int                      pos;
    bit                      found;
    v     = it.value;
    n     = list_values.size();
    pos   = n;
    found = 1'b0;
    res   = '0;
    if (it.kind == KIND_INSERT) begin
      if (n >= CAPACITY) begin
        res.entry_count = ECNT_W'(n);
      end else begin
        // goes before the first entry not below it, otherwise at the end
        for (int i = 0; i < n; i++) begin
          if (v <= list_values[i]) begin
            pos = i;
            break;
          end
        end
        list_values.insert(pos, v);
        res.success     = 1'b1;
        res.position    = POS_W'(pos);
        res.entry_count = ECNT_W'(n + 1);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (list_values[i] == v) begin
          pos   = i;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        res.entry_count = ECNT_W'(n);
      end else begin
        list_values.delete(pos);
        res.success     = 1'b1;
        res.position    = POS_W'(pos);
        res.entry_count = ECNT_W'(n - 1);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t res;
    if (rst) begin
      list_values.delete();
      pending_results.delete();
    end else begin
      // the result leaving now always belongs to an older item
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %p", out_data));
        end else begin
          want = pending_results.pop_front();
          if (out_data.success !== want.success)
            report_mismatch($sformatf("success got %b expected %b",
                                      out_data.success, want.success));
          if (out_data.position !== want.position)
            report_mismatch($sformatf("position got %0d expected %0d",
                                      out_data.position, want.position));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      out_data.entry_count, want.entry_count));
        end
      end
      if (in_valid && !in_stall) begin
        apply_item(in_data, res);
        pending_results.push_back(res);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and delete items into the sorted list block: a directed run
// over the extremes, duplicates, misses and a full list, then random runs
// that swing the list between empty and full under several idling patterns.
// Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import sli_pkg::*;

  localparam int IDLE_LIMIT       = 1000;
  localparam int RANDOM_PER_PHASE = 205;
  localparam int SETTLE_CYCLES    = 10;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  logic signed [VAL_W-1:0] recent_values[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sorted_list_insert_delete u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sorted_list_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic signed [VAL_W-1:0] value);
    in_item_t it;
    it.kind  = kind;
    it.value = value;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (recent_values.size() >= 24) void'(recent_values.pop_front());
    recent_values.push_back(value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // hold the sender until every result is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // mostly values already seen or close to zero, so duplicates and hits are common
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40 && recent_values.size() > 0)
      return recent_values[$urandom_range(recent_values.size() - 1)];
    if (r < 70) return $urandom_range(16) - 8;
    if (r < 90) return $urandom;
    case ($urandom_range(3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // runs that lean towards inserts and then deletes, so the list fills and empties
  task automatic random_phase(input int count);
    int  run_left;
    bit  insert_heavy;
    logic kind;
    run_left     = 0;
    insert_heavy = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        insert_heavy = !insert_heavy;
        run_left     = $urandom_range(60, 20);
      end
      run_left--;
      kind = ($urandom_range(99) < (insert_heavy ? 75 : 25)) ? KIND_INSERT : KIND_DELETE;
      send_item(kind, pick_value());
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, append, duplicate, miss, full list
    send_item(KIND_DELETE, 32'sd5);
    send_item(KIND_INSERT, 32'sd0);
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_INSERT, 32'sd0);
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_INSERT, -32'sd1);
    send_item(KIND_DELETE, 32'sd7);
    send_item(KIND_DELETE, 32'sd0);
    send_item(KIND_DELETE, VAL_MIN);
    send_item(KIND_DELETE, VAL_MAX);
    for (int i = 0; i < 13; i++) send_item(KIND_INSERT, $urandom);
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_DELETE, VAL_MAX);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      random_phase(RANDOM_PER_PHASE);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
